// ===== rtl/lepg_pkg.sv =====
// ----------------------------------------------------------------------------
// LED effect pattern generator package
// Shared types, register indexes and constants for the pattern generator.
// ----------------------------------------------------------------------------
package lepg_pkg;

  // Effect modes as they appear in the mode register and on mode_now.
  typedef enum logic [1:0] {
    MODE_SINGLE = 2'd0,
    MODE_LINE   = 2'd1,
    MODE_BLEND  = 2'd2
  } mode_e;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SETPOINT   = 2'd0;
  localparam logic [1:0] CFG_SATURATION = 2'd1;
  localparam logic [1:0] CFG_BRIGHTNESS = 2'd2;

  localparam int unsigned CfgDataWidth = 24;

  // Register reset values.
  localparam logic [23:0] SETPOINT_RST   = 24'h0000FF;
  localparam logic [7:0]  SATURATION_RST = 8'd204;
  localparam logic [7:0]  BRIGHTNESS_RST = 8'd204;

  // Fixed colors of the rotating line, GRB order.
  localparam logic [23:0] COL_PINK  = 24'h14FF93;
  localparam logic [23:0] COL_GREEN = 24'hFF0000;
  localparam logic [23:0] COL_BLUE  = 24'h0000FF;

  // The hue is kept as a 60 degree sector and the remainder inside it.
  localparam logic [5:0] HUE_SECTOR  = 6'd60;
  localparam logic [5:0] REM_LAST    = 6'd59;
  localparam logic [2:0] SECTOR_LAST = 3'd5;

  // Full scale of the shared conversion formula: 255 * 60.
  localparam logic [13:0] FULL_SCALE = 14'd15300;

  // Reciprocal of FULL_SCALE: ceil(2^36 / 15300). Exact for every numerator
  // below 255 * 15300.
  localparam logic [22:0] RECIP_FULL  = 23'd4491470;
  localparam int unsigned RecipShift  = 36;

  // Input item of one frame tick.
  typedef struct packed {
    logic req_single;
    logic req_line;
    logic req_blend;
  } in_t;

  // Result item of one frame tick.
  typedef struct packed {
    logic [23:0] color_first;
    logic [23:0] color_second;
    logic [23:0] color_third;
    logic [1:0]  mode_now;
  } out_t;

  // Start of one hue conversion.
  typedef struct packed {
    logic       start;
    logic [2:0] sector;
    logic [5:0] rem;
  } hsv_req_t;

  // Completion of one hue conversion.
  typedef struct packed {
    logic        done;
    logic [23:0] word;
  } hsv_rsp_t;

endpackage

// ===== rtl/lepg_hsv_unit.sv =====
// ----------------------------------------------------------------------------
// HSV conversion unit
// Converts one hue sector and remainder with the saturation and brightness
// registers to a GRB word, using one shared multiplier under a sequencer.
// ----------------------------------------------------------------------------
module lepg_hsv_unit import lepg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  hsv_req_t   req_i,
  input  logic [7:0] sat_i,
  input  logic [7:0] bri_i,
  output hsv_rsp_t   rsp_o
);

  // Channel being computed: p, q or t.
  localparam logic [1:0] CH_P = 2'd0;
  localparam logic [1:0] CH_Q = 2'd1;
  localparam logic [1:0] CH_T = 2'd2;

  typedef enum logic [5:0] {
    HS_IDLE = 6'b000001,
    HS_SK   = 6'b000010,
    HS_VF   = 6'b000100,
    HS_RC   = 6'b001000,
    HS_WB   = 6'b010000,
    HS_DONE = 6'b100000
  } hsv_state_e;

  hsv_state_e  state_q, state_d;
  logic [1:0]  ch_q, ch_d;
  logic [2:0]  sec_q;
  logic [5:0]  rem_q;
  logic [44:0] prod_q;
  logic [7:0]  chan_q [3];

  logic [5:0]  k_sel;
  logic [21:0] mul_a;
  logic [22:0] mul_b;
  logic [44:0] prod_d;
  logic [7:0]  r_ch, g_ch, b_ch;

  // Each channel is floor(V * (15300 - S * k) / 15300); k = 60 gives p.
  always_comb begin
    case (ch_q)
      CH_P:    k_sel = HUE_SECTOR;
      CH_Q:    k_sel = rem_q;
      default: k_sel = HUE_SECTOR - rem_q;
    endcase
  end

  // Operand selection of the shared multiplier for each step.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      HS_SK: begin
        mul_a = 22'(sat_i);
        mul_b = 23'(k_sel);
      end
      HS_VF: begin
        mul_a = 22'(bri_i);
        mul_b = 23'(FULL_SCALE - prod_q[13:0]);
      end
      HS_RC: begin
        mul_a = prod_q[21:0];
        mul_b = RECIP_FULL;
      end
      default: ;
    endcase
  end

  assign prod_d = {23'b0, mul_a} * {22'b0, mul_b};

  // Product register after the multiplier.
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // Sequencer: three multiplies and a write back per channel.
  always_comb begin
    state_d = state_q;
    ch_d    = ch_q;
    unique case (state_q)
      HS_IDLE: begin
        if (req_i.start) begin
          state_d = HS_SK;
          ch_d    = CH_P;
        end
      end
      HS_SK: state_d = HS_VF;
      HS_VF: state_d = HS_RC;
      HS_RC: state_d = HS_WB;
      HS_WB: begin
        if (ch_q == CH_T) begin
          state_d = HS_DONE;
        end else begin
          state_d = HS_SK;
          ch_d    = ch_q + 2'd1;
        end
      end
      HS_DONE: state_d = HS_IDLE;
      default: state_d = HS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= HS_IDLE;
      ch_q    <= CH_P;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
    end
  end

  // Captured hue and the finished channel values.
  always_ff @(posedge clk_i) begin
    if (state_q == HS_IDLE && req_i.start) begin
      sec_q <= req_i.sector;
      rem_q <= req_i.rem;
    end
    if (state_q == HS_WB) begin
      chan_q[ch_q] <= prod_q[RecipShift+7:RecipShift];
    end
  end

  // Sector table; sectors beyond the last use the last rule.
  always_comb begin
    case (sec_q)
      3'd0: begin r_ch = bri_i;     g_ch = chan_q[2]; b_ch = chan_q[0]; end
      3'd1: begin r_ch = chan_q[1]; g_ch = bri_i;     b_ch = chan_q[0]; end
      3'd2: begin r_ch = chan_q[0]; g_ch = bri_i;     b_ch = chan_q[2]; end
      3'd3: begin r_ch = chan_q[0]; g_ch = chan_q[1]; b_ch = bri_i;     end
      3'd4: begin r_ch = chan_q[2]; g_ch = chan_q[0]; b_ch = bri_i;     end
      default: begin r_ch = bri_i;  g_ch = chan_q[0]; b_ch = chan_q[1]; end
    endcase
  end

  assign rsp_o.done = (state_q == HS_DONE);
  assign rsp_o.word = {g_ch, r_ch, b_ch};

endmodule

// ===== rtl/led_effect_pattern_generator.sv =====
// ----------------------------------------------------------------------------
// LED effect pattern generator
// Produces the three repeating GRB words of an LED strip for each frame tick.
// ----------------------------------------------------------------------------
// Each transfer on the input channel is one frame tick with mode requests; it
// gives one result with the three GRB words and the mode after the tick.
// Single color and rotating line ticks are computed in the cycle of the
// transfer, and their result is valid from the next cycle, so such ticks can
// follow one per cycle while the output drains. A hue blend tick runs the HSV
// conversion on one shared multiplier: for each of the three channels it does
// three multiplies and a write back, and a done state completes it. The input
// is not ready during the conversion, so no tick is taken until it ends. The
// input is ready again once the block is idle and the output register is
// empty or being drained.
module led_effect_pattern_generator import lepg_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  in_t                     in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output out_t                    out_data_o,
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_index_i,
  input  logic [CfgDataWidth-1:0] cfg_wdata_i
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_CONV = 2'b10
  } state_e;

  state_e      state_q, state_d;
  mode_e       mode_q, mode_d;
  logic [2:0]  pending_q, pending_d;
  logic [1:0]  phase_q, phase_d;
  logic [2:0]  sector_q, sector_d;
  logic [5:0]  rem_q, rem_d;
  logic [23:0] setpoint_q;
  logic [7:0]  sat_q, bri_q;
  logic        out_valid_q;
  out_t        out_data_q;

  logic        in_fire;
  logic [2:0]  pend;
  logic [23:0] c0, c1, c2;
  hsv_req_t    hsv_req;
  hsv_rsp_t    hsv_rsp;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q <= SETPOINT_RST;
      sat_q      <= SATURATION_RST;
      bri_q      <= BRIGHTNESS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SETPOINT:   setpoint_q <= cfg_wdata_i;
        CFG_SATURATION: sat_q      <= cfg_wdata_i[7:0];
        CFG_BRIGHTNESS: bri_q      <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;

  // New requests join the pending set before the mode decision.
  assign pend = pending_q | {in_data_i.req_blend, in_data_i.req_line,
                             in_data_i.req_single};

  // Colors of the current mode, mode decision and state stepping.
  always_comb begin
    mode_d    = mode_q;
    pending_d = pending_q;
    phase_d   = phase_q;
    sector_d  = sector_q;
    rem_d     = rem_q;
    c0        = setpoint_q;
    c1        = setpoint_q;
    c2        = setpoint_q;
    if (in_fire) begin
      pending_d = pend;
      case (mode_q)
        MODE_LINE: begin
          case (phase_q)
            2'd1: begin c0 = COL_BLUE;  c1 = COL_PINK;  c2 = COL_GREEN; end
            2'd2: begin c0 = COL_GREEN; c1 = COL_BLUE;  c2 = COL_PINK;  end
            default: begin c0 = COL_PINK; c1 = COL_GREEN; c2 = COL_BLUE; end
          endcase
          case (phase_q)
            2'd0:    phase_d = 2'd1;
            2'd1:    phase_d = 2'd2;
            default: phase_d = 2'd0;
          endcase
          if (pend[0]) begin
            pending_d = pend & 3'b100;
            mode_d    = MODE_SINGLE;
          end else if (pend[2]) begin
            pending_d = pend & 3'b001;
            mode_d    = MODE_BLEND;
          end
        end
        MODE_BLEND: begin
          // Hue steps by one and wraps from 359 to 0.
          if (rem_q >= REM_LAST) begin
            rem_d    = '0;
            sector_d = (sector_q >= SECTOR_LAST) ? 3'd0 : sector_q + 3'd1;
          end else begin
            rem_d = rem_q + 6'd1;
          end
          if (pend[0]) begin
            pending_d = pend & 3'b010;
            mode_d    = MODE_SINGLE;
          end else if (pend[1]) begin
            pending_d = pend & 3'b001;
            mode_d    = MODE_LINE;
          end
        end
        default: begin
          // Single color; the unused code behaves the same.
          if (pend[1]) begin
            pending_d = pend & 3'b100;
            mode_d    = MODE_LINE;
          end else if (pend[2]) begin
            pending_d = pend & 3'b010;
            mode_d    = MODE_BLEND;
          end else begin
            mode_d = MODE_SINGLE;
          end
        end
      endcase
    end
  end

  // Blend ticks hand the current hue to the conversion unit.
  assign hsv_req.start  = in_fire && (mode_q == MODE_BLEND);
  assign hsv_req.sector = sector_q;
  assign hsv_req.rem    = rem_q;

  lepg_hsv_unit u_hsv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (hsv_req),
    .sat_i  (sat_q),
    .bri_i  (bri_q),
    .rsp_o  (hsv_rsp)
  );

  // Control sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (hsv_req.start) state_d = ST_CONV;
      ST_CONV: if (hsv_rsp.done)  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      mode_q    <= MODE_SINGLE;
      pending_q <= '0;
      phase_q   <= '0;
      sector_q  <= '0;
      rem_q     <= '0;
    end else begin
      state_q   <= state_d;
      mode_q    <= mode_d;
      pending_q <= pending_d;
      phase_q   <= phase_d;
      sector_q  <= sector_d;
      rem_q     <= rem_d;
    end
  end

  // Output register: loaded at the transfer (valid at once except for blend ticks), or when the conversion ends.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((in_fire && mode_q != MODE_BLEND) || hsv_rsp.done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q.mode_now     <= mode_d;
      out_data_q.color_first  <= c0;
      out_data_q.color_second <= c1;
      out_data_q.color_third  <= c2;
    end else if (hsv_rsp.done) begin
      out_data_q.color_first  <= hsv_rsp.word;
      out_data_q.color_second <= hsv_rsp.word;
      out_data_q.color_third  <= hsv_rsp.word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A conversion in flight blocks new ticks.
  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CONV |-> !in_ready_o)
    else $error("input ready during a hue conversion");

  // The conversion only completes while the block waits for it.
  a_done_in_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hsv_rsp.done |-> state_q == ST_CONV)
    else $error("conversion finished while idle");

  // A blend tick leaves the output empty until its conversion completes.
  a_blend_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hsv_req.start |=> !out_valid_q)
    else $error("result shown before the blend conversion finished");

  // The hue stays within 0..359.
  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= REM_LAST && sector_q <= SECTOR_LAST)
    else $error("hue out of range");

endmodule
